>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define FHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/fhc_pkg.sv
`default_nettype none

package fhc_pkg;

  // Byte counter
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam int HEADER_BYTES = 12;
  localparam logic [POS_W-1:0] HDR_LEN = POS_W'(HEADER_BYTES);

  // Header byte offsets
  localparam logic [3:0] OFS_VERSION = 4'd2;
  localparam logic [3:0] OFS_TYPE    = 4'd3;
  localparam logic [3:0] OFS_NONCE   = 4'd4;
  localparam logic [3:0] OFS_LENGTH  = 4'd8;
  localparam logic [3:0] OFS_RSVD    = 4'd10;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_ENDIAN  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_MAGIC    = 3'd2;
  localparam logic [2:0] ERR_VERSION  = 3'd3;
  localparam logic [2:0] ERR_LENGTH   = 3'd4;
  localparam logic [2:0] ERR_RESERVED = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [7:0]  frame_type;
    logic [31:0] frame_nonce;
    logic [15:0] payload_len;
  } out_word_t;

  typedef struct packed {
    logic [15:0] expected_magic;
    logic [7:0]  expected_version;
    logic        big_endian;
  } cfg_regs_t;

  // Classified byte handed from the front to the back
  typedef struct packed {
    logic        payload;
    logic [7:0]  data_byte;
    logic        last;
    logic        short_msg;
    logic        len_ok;
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  ftype;
    logic [31:0] nonce;
    logic [15:0] length;
    logic [15:0] reserved;
  } cls_word_t;

endpackage

`default_nettype wire

>>> rtl/fhc_queue.sv
`default_nettype none

module fhc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire fhc_pkg::cls_word_t push_word,
  output logic                    full,
  input  wire logic               pop,
  output fhc_pkg::cls_word_t      head_word,
  output logic                    empty
);

  fhc_pkg::cls_word_t              mem_r [fhc_pkg::QUEUE_DEPTH];
  logic [fhc_pkg::QIDX_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [fhc_pkg::QCNT_W-1:0]      cnt_r;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == fhc_pkg::QCNT_W'(fhc_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  assign head_word = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fhc_front.sv
`default_nettype none

module fhc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fhc_pkg::cfg_regs_t  cfg,
  input  wire fhc_pkg::in_word_t   in_word,
  input  wire logic                accept,
  output fhc_pkg::cls_word_t       cls_word
);

  logic [fhc_pkg::POS_W-1:0] pos_r, pos_inc;
  logic [15:0] seen_magic_r,    seen_magic_nxt;
  logic [7:0]  seen_version_r,  seen_version_nxt;
  logic [7:0]  seen_type_r,     seen_type_nxt;
  logic [31:0] seen_nonce_r,    seen_nonce_nxt;
  logic [15:0] seen_length_r,   seen_length_nxt;
  logic [15:0] seen_reserved_r, seen_reserved_nxt;
  logic        in_hdr;
  logic [3:0]  hpos;
  logic        lane2;
  logic [1:0]  lane4;
  logic [fhc_pkg::POS_W-1:0] want_total;

  assign in_hdr = (pos_r < fhc_pkg::HDR_LEN);
  assign hpos   = pos_r[3:0];
  // byte lane within the field, honoring byte order
  assign lane2  = cfg.big_endian ? ~hpos[0] : hpos[0];
  assign lane4  = cfg.big_endian ? ~hpos[1:0] : hpos[1:0];

  // header capture, current byte included
  always_comb begin
    seen_magic_nxt    = seen_magic_r;
    seen_version_nxt  = seen_version_r;
    seen_type_nxt     = seen_type_r;
    seen_nonce_nxt    = seen_nonce_r;
    seen_length_nxt   = seen_length_r;
    seen_reserved_nxt = seen_reserved_r;
    if (in_hdr) begin
      if (hpos < fhc_pkg::OFS_VERSION) begin
        seen_magic_nxt[{lane2, 3'b000} +: 8] = in_word.data_byte;
      end else if (hpos == fhc_pkg::OFS_VERSION) begin
        seen_version_nxt = in_word.data_byte;
      end else if (hpos == fhc_pkg::OFS_TYPE) begin
        seen_type_nxt = in_word.data_byte;
      end else if (hpos < fhc_pkg::OFS_LENGTH) begin
        seen_nonce_nxt[{lane4, 3'b000} +: 8] = in_word.data_byte;
      end else if (hpos < fhc_pkg::OFS_RSVD) begin
        seen_length_nxt[{lane2, 3'b000} +: 8] = in_word.data_byte;
      end else begin
        seen_reserved_nxt[{lane2, 3'b000} +: 8] = in_word.data_byte;
      end
    end
  end

  // saturating count and length checks
  assign pos_inc    = (pos_r == fhc_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
  assign want_total = {1'b0, seen_length_nxt} + fhc_pkg::HDR_LEN;

  always_comb begin
    cls_word.payload   = !in_hdr;
    cls_word.data_byte = in_word.data_byte;
    cls_word.last      = in_word.last;
    cls_word.short_msg = (pos_inc < fhc_pkg::HDR_LEN);
    cls_word.len_ok    = (pos_inc == want_total);
    cls_word.magic     = seen_magic_nxt;
    cls_word.version   = seen_version_nxt;
    cls_word.ftype     = seen_type_nxt;
    cls_word.nonce     = seen_nonce_nxt;
    cls_word.length    = seen_length_nxt;
    cls_word.reserved  = seen_reserved_nxt;
  end

  // message state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r           <= '0;
      seen_magic_r    <= '0;
      seen_version_r  <= '0;
      seen_type_r     <= '0;
      seen_nonce_r    <= '0;
      seen_length_r   <= '0;
      seen_reserved_r <= '0;
    end else if (accept) begin
      if (in_word.last) begin
        pos_r           <= '0;
        seen_magic_r    <= '0;
        seen_version_r  <= '0;
        seen_type_r     <= '0;
        seen_nonce_r    <= '0;
        seen_length_r   <= '0;
        seen_reserved_r <= '0;
      end else begin
        pos_r           <= pos_inc;
        seen_magic_r    <= seen_magic_nxt;
        seen_version_r  <= seen_version_nxt;
        seen_type_r     <= seen_type_nxt;
        seen_nonce_r    <= seen_nonce_nxt;
        seen_length_r   <= seen_length_nxt;
        seen_reserved_r <= seen_reserved_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/fhc_back.sv
`default_nettype none

module fhc_back (
  input  wire fhc_pkg::cfg_regs_t  cfg,
  input  wire fhc_pkg::cls_word_t  cls_word,
  output fhc_pkg::out_word_t       out_word
);

  logic [2:0] code;

  // verdict, first failing check wins
  always_comb begin
    if (cls_word.short_msg) begin
      code = fhc_pkg::ERR_SHORT;
    end else if (cls_word.magic != cfg.expected_magic) begin
      code = fhc_pkg::ERR_MAGIC;
    end else if (cls_word.version != cfg.expected_version) begin
      code = fhc_pkg::ERR_VERSION;
    end else if (!cls_word.len_ok) begin
      code = fhc_pkg::ERR_LENGTH;
    end else if (cls_word.reserved != '0) begin
      code = fhc_pkg::ERR_RESERVED;
    end else begin
      code = fhc_pkg::ERR_OK;
    end
  end

  // result word; verdict fields zero unless last
  always_comb begin
    out_word.payload_valid = cls_word.payload;
    out_word.payload_byte  = cls_word.payload ? cls_word.data_byte : '0;
    out_word.frame_done    = cls_word.last;
    out_word.frame_ok      = cls_word.last && (code == fhc_pkg::ERR_OK);
    out_word.error_code    = cls_word.last ? code : fhc_pkg::ERR_OK;
    out_word.frame_type    = cls_word.last ? cls_word.ftype : '0;
    out_word.frame_nonce   = cls_word.last ? cls_word.nonce : '0;
    out_word.payload_len   = cls_word.last ? cls_word.length : '0;
  end

endmodule

`default_nettype wire

>>> rtl/frame_header_checker_top.sv
`default_nettype none

// Byte-serial frame header checker. Takes one message byte per cycle (in_push
// while in_full is low) and gives exactly one result word per byte: payload
// bytes past the 12-byte header come out with payload_valid set, and the byte
// flagged last carries the verdict, error code and the captured type, nonce and
// payload length. The front captures header fields and classifies each byte in
// the cycle it is taken; a 4-entry queue decouples it from the result side, and
// the verdict is formed at the queue head, so a result is visible once its byte is
// written into the queue, and one byte per cycle flows as long as out_pop keeps
// up. in_full rises only when four results wait. cfg_ready is always high;
// write configuration only while no result is pending.
module frame_header_checker_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // byte input
  input  wire fhc_pkg::in_word_t  in_word,
  input  wire logic               in_push,
  output logic                    in_full,
  // results
  output fhc_pkg::out_word_t      out_word,
  output logic                    out_empty,
  input  wire logic               out_pop,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  fhc_pkg::cfg_regs_t  cfg_r;
  fhc_pkg::cls_word_t  front_word, head_word;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic   <= '0;
      cfg_r.expected_version <= '0;
      cfg_r.big_endian       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fhc_pkg::CFG_MAGIC:   cfg_r.expected_magic   <= cfg_data;
        fhc_pkg::CFG_VERSION: cfg_r.expected_version <= cfg_data[7:0];
        fhc_pkg::CFG_ENDIAN:  cfg_r.big_endian       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fhc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_word  (in_word),
    .accept   (accept),
    .cls_word (front_word)
  );

  fhc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_word (front_word),
    .full      (in_full),
    .pop       (out_pop),
    .head_word (head_word),
    .empty     (out_empty)
  );

  fhc_back u_back (
    .cfg      (cfg_r),
    .cls_word (head_word),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

>>> rtl/fhc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module fhc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_push,
  input wire logic                in_full,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire fhc_pkg::out_word_t  out_word
);

  // nothing waits right after reset
  `FHC_ASSERT(a_empty_after_rst, !$past(rst_n) |-> out_empty, "results pending after reset")

  // a taken byte always leaves a result behind
  `FHC_ASSERT(a_push_shows, (in_push && !in_full) |=> !out_empty, "taken word produced no result")

  // full only when results are waiting
  `FHC_ASSERT(a_full_nonempty, in_full |-> !out_empty, "full with no result waiting")

  // a waiting result holds until popped
  `FHC_ASSERT(a_out_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)), "result changed while waiting")

endmodule

bind frame_header_checker_top fhc_checker u_fhc_checker (.*);

`default_nettype wire
